/* rtl/xcbc_pkg.sv */
// Shared types, constants and the mixing function of the XTEA CBC decipher.
// No dependencies; every other file takes names from here by scope.
package xcbc_pkg;

  localparam int unsigned ROUND_PAIRS_DEFAULT = 32;

  localparam logic [31:0] DELTA           = 32'h9E3779B9;
  localparam logic [31:0] KEY0_RESET      = 32'h7B2E1A4F;
  localparam logic [31:0] KEY1_RESET      = 32'hC9D83560;
  localparam logic [31:0] KEY2_RESET      = 32'h4A1F93E7;
  localparam logic [31:0] KEY3_RESET      = 32'hE8056B2C;
  localparam logic [31:0] IV_FIRST_RESET  = 32'hDEADBEEF;
  localparam logic [31:0] IV_SECOND_RESET = 32'hCAFEBABE;

  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY0      = 3'd0,
    REG_KEY1      = 3'd1,
    REG_KEY2      = 3'd2,
    REG_KEY3      = 3'd3,
    REG_IV_FIRST  = 3'd4,
    REG_IV_SECOND = 3'd5
  } reg_index_t;

  typedef logic [3:0][31:0] key_t;

  typedef struct packed {
    logic [31:0] cipher_first;
    logic [31:0] cipher_second;
    logic        first_block;
  } in_t;

  typedef struct packed {
    logic [31:0] plain_first;
    logic [31:0] plain_second;
  } out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] chain_first;
    logic [31:0] chain_second;
  } stage_t;

  function automatic logic [31:0] mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

/* rtl/xtea_cbc_decipher_top.sv */
// Top level of the XTEA CBC decipher: configuration registers, chain state,
// the half-round pipeline (xcbc_half) and the output stage (xcbc_out); uses xcbc_pkg.
//
//   channel | direction | handshake        | payload
//   in      | into      | in_valid/in_stall  | in_data  (cipher_first, cipher_second,
//           |           |                    |           first_block)
//   out     | out of    | out_valid/out_stall| out_data (plain_first, plain_second)
//   cfg     | into      | cfg_write          | cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low; each result passes through
// one registered half round per stage and then the output register.
// Reset clears all valid bits and loads key, IV and chain registers with their defaults.
// The pipeline holds while the skid register is full; in_stall is that registered bit.
module xtea_cbc_decipher_top #(
  parameter int unsigned ROUND_PAIRS = xcbc_pkg::ROUND_PAIRS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  xcbc_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output xcbc_pkg::out_t                     out_data,
  input  logic                               cfg_write,
  input  logic [xcbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data
);

  localparam int unsigned STAGES = 2 * ROUND_PAIRS;

  xcbc_pkg::key_t   key;
  logic [31:0]      iv_first;
  logic [31:0]      iv_second;
  logic [31:0]      chain_first;
  logic [31:0]      chain_second;
  logic             advance;
  logic             in_take;
  logic             stage_valid [0:STAGES];
  xcbc_pkg::stage_t stage_data  [0:STAGES];

  assign in_stall = !advance;
  assign in_take  = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0]    <= xcbc_pkg::KEY0_RESET;
      key[1]    <= xcbc_pkg::KEY1_RESET;
      key[2]    <= xcbc_pkg::KEY2_RESET;
      key[3]    <= xcbc_pkg::KEY3_RESET;
      iv_first  <= xcbc_pkg::IV_FIRST_RESET;
      iv_second <= xcbc_pkg::IV_SECOND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        xcbc_pkg::REG_KEY0:      key[0]    <= cfg_data;
        xcbc_pkg::REG_KEY1:      key[1]    <= cfg_data;
        xcbc_pkg::REG_KEY2:      key[2]    <= cfg_data;
        xcbc_pkg::REG_KEY3:      key[3]    <= cfg_data;
        xcbc_pkg::REG_IV_FIRST:  iv_first  <= cfg_data;
        xcbc_pkg::REG_IV_SECOND: iv_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_first  <= xcbc_pkg::IV_FIRST_RESET;
      chain_second <= xcbc_pkg::IV_SECOND_RESET;
    end else if (in_take) begin
      chain_first  <= in_data.cipher_first;
      chain_second <= in_data.cipher_second;
    end
  end

  always_comb begin
    stage_valid[0]         = in_valid;
    stage_data[0].a        = in_data.cipher_first;
    stage_data[0].b        = in_data.cipher_second;
    stage_data[0].chain_first  = in_data.first_block ? iv_first  : chain_first;
    stage_data[0].chain_second = in_data.first_block ? iv_second : chain_second;
  end

  for (genvar p = 0; p < ROUND_PAIRS; p++) begin : g_pair
    localparam logic [31:0] SUM_HI =
      32'(64'(ROUND_PAIRS - p) * 64'(xcbc_pkg::DELTA));
    localparam logic [31:0] SUM_LO =
      32'(64'(ROUND_PAIRS - p - 1) * 64'(xcbc_pkg::DELTA));

    xcbc_half #(.SUM(SUM_HI), .SECOND_WORD(1'b1)) u_half_b (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (stage_valid[2*p]),
      .in_data   (stage_data[2*p]),
      .key       (key),
      .out_valid (stage_valid[2*p+1]),
      .out_data  (stage_data[2*p+1])
    );

    xcbc_half #(.SUM(SUM_LO), .SECOND_WORD(1'b0)) u_half_a (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (stage_valid[2*p+1]),
      .in_data   (stage_data[2*p+1]),
      .key       (key),
      .out_valid (stage_valid[2*p+2]),
      .out_data  (stage_data[2*p+2])
    );
  end

  xcbc_out u_out (
    .clk        (clk),
    .rst        (rst),
    .tail_valid (stage_valid[STAGES]),
    .tail_data  (stage_data[STAGES]),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* rtl/xcbc_half.sv */
// One registered half round of the XTEA decipher with a fixed round sum.
// Depends on xcbc_pkg.
module xcbc_half #(
  parameter logic [31:0] SUM         = 32'h0,
  parameter bit          SECOND_WORD = 1'b1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  xcbc_pkg::stage_t in_data,
  input  xcbc_pkg::key_t   key,
  output logic            out_valid,
  output xcbc_pkg::stage_t out_data
);

  localparam logic [1:0] KEY_SEL = SECOND_WORD ? SUM[12:11] : SUM[1:0];

  xcbc_pkg::stage_t stage_next;
  logic [31:0]      tweak;

  always_comb begin
    stage_next = in_data;
    tweak      = SUM + key[KEY_SEL];
    if (SECOND_WORD) begin
      stage_next.b = in_data.b - (xcbc_pkg::mix(in_data.a) ^ tweak);
    end else begin
      stage_next.a = in_data.a - (xcbc_pkg::mix(in_data.b) ^ tweak);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= stage_next;
    end
  end

endmodule

/* rtl/xcbc_out.sv */
// Chain XOR, output register and skid register of the decipher pipeline.
// Depends on xcbc_pkg.
module xcbc_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             tail_valid,
  input  xcbc_pkg::stage_t tail_data,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_stall,
  output xcbc_pkg::out_t   out_data
);

  xcbc_pkg::out_t result;
  xcbc_pkg::out_t skid_data;
  logic           skid_valid;
  logic           out_take;

  assign result.plain_first  = tail_data.a ^ tail_data.chain_first;
  assign result.plain_second = tail_data.b ^ tail_data.chain_second;
  assign out_take            = out_valid && !out_stall;
  assign advance             = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_take) begin
      out_valid <= tail_valid;
      out_data  <= result;
    end else if (tail_valid) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> !skid_valid)
    else $error("skid register not drained after output taken");

  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    !skid_valid && out_valid && out_stall && tail_valid |=> skid_valid && out_valid)
    else $error("arriving request not caught while output stalled");

endmodule

/* verif/xtea_cbc_decipher_top_tb.sv */
// Testbench for xtea_cbc_decipher_top: directed table, then random CBC messages with random
// idling on both sides, checked against an XTEA CBC decipher predictor in this file.
// Depends on xcbc_pkg and xtea_cbc_decipher_top.
module xtea_cbc_decipher_top_tb;

  localparam int ROUNDS = xcbc_pkg::ROUND_PAIRS_DEFAULT;
  localparam int CFG_W = xcbc_pkg::CFG_INDEX_W;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 240;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 2 * ROUNDS + 16;
  localparam longint LIMIT_CYCLES = 2_000_000;
  localparam logic [CFG_W-1:0] REG_UNUSED6 = 3'd6;
  localparam logic [CFG_W-1:0] REG_UNUSED7 = 3'd7;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [CFG_W-1:0]  idx;
    logic [31:0]       w0;
    logic [31:0]       w1;
    logic              first;
  } step_t;

  localparam int N_DIRECTED = 27;
  step_t directed_steps [N_DIRECTED] = '{
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'h0000_0000, 32'h0000_0000, 1'b1},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'h0000_0000, 32'hFFFF_FFFF, 1'b1},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'hAAAA_AAAA, 32'h5555_5555, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_KEY0,      32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_KEY1,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_KEY2,      32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_KEY3,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'h1234_5678, 32'h9ABC_DEF0, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_IV_FIRST,  32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_IV_SECOND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'h5555_5555, 32'hAAAA_AAAA, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'h0000_0000, 32'h0000_0000, 1'b1},
    '{ROW_WRITE, REG_UNUSED6,             32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, REG_UNUSED7,             32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
    '{ROW_WRITE, xcbc_pkg::REG_KEY0,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_KEY1,      32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_KEY2,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_KEY3,      32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_IV_FIRST,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{ROW_WRITE, xcbc_pkg::REG_IV_SECOND, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'h8000_0000, 32'h0000_0001, 1'b1},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'h0000_0001, 32'h8000_0000, 1'b0},
    '{ROW_ITEM,  xcbc_pkg::REG_KEY0,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}
  };

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  xcbc_pkg::in_t          in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  xcbc_pkg::out_t         out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_W-1:0]       cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  logic [31:0]    pred_key [4];
  logic [31:0]    pred_iv_first;
  logic [31:0]    pred_iv_second;
  logic [31:0]    pred_chain_first;
  logic [31:0]    pred_chain_second;
  xcbc_pkg::out_t plain_q [$];
  int             errors = 0;
  bit             hold_req = 1'b0;
  bit             hold_done = 1'b0;

  xtea_cbc_decipher_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 4);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] round_mix(input logic [31:0] v);
    return ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic xcbc_pkg::out_t decipher_block(input xcbc_pkg::in_t req);
    logic [31:0]    a;
    logic [31:0]    b;
    logic [31:0]    sum;
    xcbc_pkg::out_t res;
    a = req.cipher_first;
    b = req.cipher_second;
    sum = '0;
    repeat (ROUNDS) sum += xcbc_pkg::DELTA;
    repeat (ROUNDS) begin
      b -= round_mix(a) ^ (sum + pred_key[sum[12:11]]);
      sum -= xcbc_pkg::DELTA;
      a -= round_mix(b) ^ (sum + pred_key[sum[1:0]]);
    end
    if (req.first_block) begin
      pred_chain_first = pred_iv_first;
      pred_chain_second = pred_iv_second;
    end
    res.plain_first = a ^ pred_chain_first;
    res.plain_second = b ^ pred_chain_second;
    pred_chain_first = req.cipher_first;
    pred_chain_second = req.cipher_second;
    return res;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 15))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input xcbc_pkg::in_t req);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    plain_q.push_back(decipher_block(req));
  endtask

  task automatic drop_valid(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx <= xcbc_pkg::REG_KEY3) pred_key[idx[1:0]] = val;
    else if (idx == xcbc_pkg::REG_IV_FIRST) pred_iv_first = val;
    else if (idx == xcbc_pkg::REG_IV_SECOND) pred_iv_second = val;
  endtask

  task automatic configure_phase(input int p);
    logic [CFG_W-1:0] idx;
    for (int r = xcbc_pkg::REG_KEY0; r <= xcbc_pkg::REG_IV_SECOND; r++) begin
      idx = CFG_W'(r);
      case (p % 4)
        1: cfg_put(idx, 32'h0000_0000);
        2: cfg_put(idx, 32'hFFFF_FFFF);
        3: if ($urandom_range(0, 1)) cfg_put(idx, random_word());
        default: cfg_put(idx, random_word());
      endcase
    end
    if (p % 4 == 3) begin
      cfg_put(REG_UNUSED6, $urandom);
      cfg_put(REG_UNUSED7, $urandom);
    end
  endtask

  // release the result port on a rotating stall pattern, with one long hold-off
  initial begin
    int         seg_len;
    logic [7:0] pattern;
    @(negedge clk iff !rst);
    forever begin
      if (hold_req && !hold_done) begin
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end else begin
        seg_len = $urandom_range(8, 120);
        pattern = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        for (int i = 0; i < seg_len && !(hold_req && !hold_done); i++) begin
          @(negedge clk);
          out_stall <= pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
      end
    end
  end

  always @(posedge clk) begin
    xcbc_pkg::out_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (plain_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_res = plain_q.pop_front();
        if (out_data.plain_first !== exp_res.plain_first) begin
          $display("%0t: plain_first expected %h got %h", $time,
                   exp_res.plain_first, out_data.plain_first);
          errors++;
        end
        if (out_data.plain_second !== exp_res.plain_second) begin
          $display("%0t: plain_second expected %h got %h", $time,
                   exp_res.plain_second, out_data.plain_second);
          errors++;
        end
      end
    end
  end

  initial begin
    xcbc_pkg::in_t req;
    int            sent;
    int            burst;
    pred_key[0] = xcbc_pkg::KEY0_RESET;
    pred_key[1] = xcbc_pkg::KEY1_RESET;
    pred_key[2] = xcbc_pkg::KEY2_RESET;
    pred_key[3] = xcbc_pkg::KEY3_RESET;
    pred_iv_first = xcbc_pkg::IV_FIRST_RESET;
    pred_iv_second = xcbc_pkg::IV_SECOND_RESET;
    pred_chain_first = xcbc_pkg::IV_FIRST_RESET;
    pred_chain_second = xcbc_pkg::IV_SECOND_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_steps[s]) begin
      if (directed_steps[s].kind == ROW_WRITE) begin
        wait_drained();
        cfg_put(directed_steps[s].idx, directed_steps[s].w0);
      end else begin
        req.cipher_first = directed_steps[s].w0;
        req.cipher_second = directed_steps[s].w1;
        req.first_block = directed_steps[s].first;
        send_request(req);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      configure_phase(p);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          req.cipher_first = random_word();
          req.cipher_second = random_word();
          req.first_block = ($urandom_range(0, 7) == 0);
          send_request(req);
          sent++;
          if (p == 1 && sent == 20) hold_req = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) drop_valid($urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (plain_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, plain_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
